@@ sv/ihex_pkg.sv @@
// Shared types, constants and helpers for the Intel HEX record parser.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package ihex_pkg;

    // Size of the target image, in bytes
    localparam int unsigned IMAGE_BYTES = 131072;

    localparam int ADDR_W  = 17;
    localparam int TOTAL_W = 24;
    localparam int POS_W   = 10;

    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Characters with a meaning of their own
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Record types
    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_EOF     = 8'h01;
    localparam logic [7:0] TYPE_EXT_SEG = 8'h02;
    localparam logic [7:0] TYPE_EXT_LIN = 8'h04;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_END     = 3'd1,
        ST_BASE    = 3'd2,
        ST_IGNORED = 3'd3,
        ST_ERROR   = 3'd4
    } line_status_t;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  byte_address;
        logic [7:0]         byte_value;
        line_status_t       line_status;
        logic [TOTAL_W-1:0] total_bytes;
    } result_t;

    typedef struct packed {
        logic end_seen;
        logic line_failed;
    } parse_status_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // ASCII hex digit decode
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.value = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r.value = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ sv/ihex_in_stage.sv @@
// Input register of the parser: holds one character request.
// Depends on nothing but the clock and reset.
module ihex_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] character
    input  logic       proceed,
    output logic       hold_valid,
    output logic [7:0] hold_char
);

    logic       valid_reg;
    logic [7:0] char_reg;

    // Open when empty or when the held character moves on this cycle
    assign s_tready   = !valid_reg || proceed;
    assign hold_valid = valid_reg;
    assign hold_char  = char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
        end
    end

endmodule

@@ sv/ihex_parse.sv @@
// Record field tracker: line state, extended base and byte total,
// updated once per character. Uses ihex_pkg.
module ihex_parse
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [7:0]             character,
    output logic                   result_valid,
    output ihex_pkg::result_t      result,
    output ihex_pkg::parse_status_t status
);

    logic [ihex_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                   len_reg, len_next;
    logic [15:0]                  offset_reg, offset_next;
    logic [7:0]                   type_reg, type_next;
    logic [7:0]                   sum_reg, sum_next;
    logic [3:0]                   nib_reg, nib_next;
    logic [15:0]                  pend_reg, pend_next;
    logic [31:0]                  base_reg, base_next;
    logic                         failed_reg, failed_next;
    logic                         end_reg, end_next;
    logic [ihex_pkg::TOTAL_W-1:0] total_reg, total_next;

    assign status.end_seen    = end_reg;
    assign status.line_failed = failed_reg;

    // Per-character next state and result
    always_comb
    begin
        logic [ihex_pkg::POS_W-1:0]  d;
        logic [ihex_pkg::POS_W:0]    span;
        logic [ihex_pkg::POS_W:0]    line_need;
        logic [ihex_pkg::POS_W-2:0]  b;
        logic [ihex_pkg::POS_W-2:0]  idx;
        logic [ihex_pkg::POS_W:0]    data_end;
        ihex_pkg::hex_digit_t        hd;
        logic [7:0]                  byte_v;
        logic [33:0]                 top;
        logic [ihex_pkg::TOTAL_W:0]  tsum;
        ihex_pkg::line_status_t      st;

        pos_next     = pos_reg;
        len_next     = len_reg;
        offset_next  = offset_reg;
        type_next    = type_reg;
        sum_next     = sum_reg;
        nib_next     = nib_reg;
        pend_next    = pend_reg;
        base_next    = base_reg;
        failed_next  = failed_reg;
        end_next     = end_reg;
        total_next   = total_reg;
        result_valid = 1'b0;
        result       = '0;

        d         = pos_reg - ihex_pkg::POS_W'(1);
        span      = (ihex_pkg::POS_W+1)'(10) + (ihex_pkg::POS_W+1)'({len_reg, 1'b0});
        line_need = (ihex_pkg::POS_W+1)'(11) + (ihex_pkg::POS_W+1)'({len_reg, 1'b0});
        b         = d[ihex_pkg::POS_W-1:1];
        idx       = b - (ihex_pkg::POS_W-1)'(4);
        data_end  = (ihex_pkg::POS_W+1)'(4) + (ihex_pkg::POS_W+1)'(len_reg);
        hd        = ihex_pkg::hex_decode(character);
        byte_v    = {nib_reg, hd.value};
        top       = 34'(offset_reg) + 34'(base_reg) + 34'(len_reg);
        tsum      = (ihex_pkg::TOTAL_W+1)'(total_reg) + (ihex_pkg::TOTAL_W+1)'(len_reg);
        st        = ihex_pkg::ST_ERROR;

        if (fire && !end_reg && character != ihex_pkg::CHAR_CR)
        begin
            if (character == ihex_pkg::CHAR_LF)
            begin
                // Line end: judge the record, then start a fresh line
                if (pos_reg == '0 || failed_reg)
                begin
                    st = ihex_pkg::ST_ERROR;
                end
                else if ({1'b0, pos_reg} < line_need)
                begin
                    st = ihex_pkg::ST_ERROR;
                end
                else if (type_reg == ihex_pkg::TYPE_DATA)
                begin
                    st = (sum_reg == 8'd0) ? ihex_pkg::ST_DATA : ihex_pkg::ST_ERROR;
                end
                else if (type_reg == ihex_pkg::TYPE_EOF)
                begin
                    st       = ihex_pkg::ST_END;
                    end_next = 1'b1;
                end
                else if (type_reg inside {ihex_pkg::TYPE_EXT_SEG, ihex_pkg::TYPE_EXT_LIN}
                         && len_reg == 8'd2 && sum_reg == 8'd0)
                begin
                    st = ihex_pkg::ST_BASE;
                    if (type_reg == ihex_pkg::TYPE_EXT_SEG)
                    begin
                        base_next = {12'd0, pend_reg, 4'd0};
                    end
                    else
                    begin
                        base_next = {pend_reg, 16'd0};
                    end
                end
                else
                begin
                    st = ihex_pkg::ST_IGNORED;
                end
                result_valid       = 1'b1;
                result.kind        = ihex_pkg::KIND_STATUS;
                result.line_status = st;
                pos_next    = '0;
                len_next    = '0;
                offset_next = '0;
                type_next   = '0;
                sum_next    = '0;
                nib_next    = '0;
                pend_next   = '0;
                failed_next = 1'b0;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    // Start of line must be a colon
                    if (character != ihex_pkg::CHAR_COLON)
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (!failed_reg && {1'b0, d} < span)
                begin
                    if (!hd.valid)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (!d[0])
                    begin
                        nib_next = hd.value;
                    end
                    else
                    begin
                        sum_next = sum_reg + byte_v;
                        if (b == '0)
                        begin
                            len_next = byte_v;
                        end
                        else if (b == (ihex_pkg::POS_W-1)'(1))
                        begin
                            offset_next = {byte_v, 8'd0};
                        end
                        else if (b == (ihex_pkg::POS_W-1)'(2))
                        begin
                            offset_next = {offset_reg[15:8], byte_v};
                        end
                        else if (b == (ihex_pkg::POS_W-1)'(3))
                        begin
                            // Type known: range check and byte count
                            type_next = byte_v;
                            if (top >= 34'(ihex_pkg::IMAGE_BYTES))
                            begin
                                failed_next = 1'b1;
                            end
                            else if (byte_v == ihex_pkg::TYPE_DATA)
                            begin
                                if (tsum > (ihex_pkg::TOTAL_W+1)'(ihex_pkg::TOTAL_MAX))
                                begin
                                    total_next = ihex_pkg::TOTAL_MAX;
                                end
                                else
                                begin
                                    total_next = tsum[ihex_pkg::TOTAL_W-1:0];
                                end
                            end
                        end
                        else if ({2'b00, b} < data_end)
                        begin
                            if (type_reg == ihex_pkg::TYPE_DATA)
                            begin
                                result_valid        = 1'b1;
                                result.kind         = ihex_pkg::KIND_DATA;
                                result.byte_address = {1'b0, offset_reg}
                                    + base_reg[ihex_pkg::ADDR_W-1:0]
                                    + ihex_pkg::ADDR_W'(idx);
                                result.byte_value   = byte_v;
                                result.line_status  = ihex_pkg::ST_DATA;
                            end
                            else
                            begin
                                pend_next = {pend_reg[7:0], byte_v};
                            end
                        end
                    end
                end
                // Character count saturates
                if (pos_reg != ihex_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + ihex_pkg::POS_W'(1);
                end
            end
        end
        result.total_bytes = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            offset_reg <= '0;
            type_reg   <= '0;
            sum_reg    <= '0;
            nib_reg    <= '0;
            pend_reg   <= '0;
            base_reg   <= '0;
            failed_reg <= 1'b0;
            end_reg    <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            offset_reg <= offset_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
            nib_reg    <= nib_next;
            pend_reg   <= pend_next;
            base_reg   <= base_next;
            failed_reg <= failed_next;
            end_reg    <= end_next;
            total_reg  <= total_next;
        end
    end

endmodule

@@ sv/ihex_out_stage.sv @@
// Result register of the parser, driving the master-side stream.
// Uses ihex_pkg::result_t.
module ihex_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ihex_pkg::result_t result,
    output logic              proceed,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,
    output logic              m_tuser
);

    logic              valid_reg;
    ihex_pkg::result_t res_reg;

    // Room for a new result when empty or when the current one leaves
    assign proceed  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {4'd0, res_reg.total_bytes, res_reg.line_status,
                       res_reg.byte_value, res_reg.byte_address};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (proceed)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && load)
        begin
            res_reg <= result;
        end
    end

endmodule

@@ sv/intel_hex_record_parser_core.sv @@
// Intel HEX record parser: top level with input register, field tracker,
// result register and checks. Depends on ihex_pkg and the three stage modules.
//
// Takes one ASCII character per request and gives at most one result per
// character: a data byte with its absolute address, or a line status at each
// line feed. Each character waits in the input register, where it is decoded,
// and its result is loaded into the result register as the character leaves
// the input register; the result register then presents it on the master
// stream. A new character is taken every cycle as long as the result side is
// not stalled. Carriage returns, characters after the checksum and all input
// after an end record produce nothing.
module intel_hex_record_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [16:0] byte_address, [24:17] byte_value,
                                   // [27:25] line_status, [51:28] total_bytes
    output logic        m_tuser    // [0] kind
);

    logic                    proceed;
    logic                    hold_valid;
    logic [7:0]              hold_char;
    logic                    fire;
    logic                    res_valid;
    ihex_pkg::result_t       result;
    ihex_pkg::parse_status_t pstat;

    assign fire = hold_valid && proceed;

    ihex_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .proceed    (proceed),
        .hold_valid (hold_valid),
        .hold_char  (hold_char)
    );

    ihex_parse u_parse
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .character    (hold_char),
        .result_valid (res_valid),
        .result       (result),
        .status       (pstat)
    );

    ihex_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .result   (result),
        .proceed  (proceed),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Nothing is produced once the end record has been taken
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        pstat.end_seen |-> !res_valid)
        else $error("result produced after end record");

    // A data byte only comes from a counted data record
    a_data_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ihex_pkg::KIND_DATA) |-> m_tdata[51:28] != '0)
        else $error("data byte with zero byte total");

    // Input side only closes while a character is held
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (hold_valid && !proceed))
        else $error("input closed without a stalled character");

endmodule

@@ tb/sv/tb_intel_hex_record_parser_core.sv @@
// Self-checking testbench for intel_hex_record_parser_core: drives hex text one
// character per request and checks every data byte and line status it returns.
// Depends on ihex_pkg and the parser RTL; needs no files or arguments.
module tb_intel_hex_record_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] gap;
    } char_req_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    intel_hex_record_parser_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Stimulus and scoreboard storage
    char_req_t   char_q[$];
    result_t     due_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned gen_count      = 0;
    int unsigned gen_base       = 0;   // extended base as the generator expects it
    bit          tx_calm        = 1'b0;
    bit          in_taken       = 1'b0;
    bit          out_taken      = 1'b0;
    int          tx_wait        = 0;
    int          rx_wait        = 0;
    int          rx_hold_left   = 0;
    int unsigned rx_results     = 0;
    bit          rx_calm        = 1'b0;

    // Parser state mirrored by the predictor
    int unsigned pos;
    int unsigned rec_len;
    int unsigned rec_off;
    logic [7:0]  rec_type;
    logic [7:0]  csum;
    logic [3:0]  hi_nib;
    logic [15:0] base_acc;
    logic [31:0] ext_base;
    bit          bad_line;
    bit          eof_seen;
    int unsigned total;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
        return -1;
    endfunction

    task automatic new_line();
        pos      = 0;
        rec_len  = 0;
        rec_off  = 0;
        rec_type = 8'h00;
        csum     = 8'h00;
        hi_nib   = 4'h0;
        base_acc = 16'h0000;
        bad_line = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c);
        int              v;
        int unsigned     d;
        int unsigned     b;
        int unsigned     bval;
        longint unsigned top;
        line_status_t    st;
        result_t         r;
        r = '0;
        if (eof_seen || c == CHAR_CR) return;

        // Line feed: close the line with a status
        if (c == CHAR_LF) begin
            if (pos == 0 || bad_line)
                st = ST_ERROR;
            else if (pos < 11 + 2 * rec_len)
                st = ST_ERROR;
            else if (rec_type == TYPE_DATA)
                st = (csum == 8'h00) ? ST_DATA : ST_ERROR;
            else if (rec_type == TYPE_EOF) begin
                st       = ST_END;
                eof_seen = 1'b1;
            end
            else if ((rec_type == TYPE_EXT_SEG || rec_type == TYPE_EXT_LIN) &&
                     rec_len == 2 && csum == 8'h00) begin
                ext_base = (rec_type == TYPE_EXT_SEG) ? {12'd0, base_acc, 4'd0}
                                                      : {base_acc, 16'd0};
                st       = ST_BASE;
            end
            else
                st = ST_IGNORED;
            r.kind        = KIND_STATUS;
            r.line_status = st;
            r.total_bytes = total[TOTAL_W-1:0];
            due_results.push_back(r);
            new_line();
            return;
        end

        if (pos == 0) begin
            if (c != CHAR_COLON) bad_line = 1'b1;
        end
        else if (!bad_line) begin
            d = pos - 1;
            // only the record span is decoded; later characters are dropped
            if (d < 10 + 2 * rec_len) begin
                v = digit_value(c);
                if (v < 0)
                    bad_line = 1'b1;
                else if (d[0] == 1'b0)
                    hi_nib = v[3:0];
                else begin
                    bval = {hi_nib, v[3:0]};
                    b    = d >> 1;
                    csum = csum + bval[7:0];
                    if (b == 0)
                        rec_len = bval;
                    else if (b == 1)
                        rec_off = bval << 8;
                    else if (b == 2)
                        rec_off = rec_off | bval;
                    else if (b == 3) begin
                        rec_type = bval[7:0];
                        top      = rec_off;
                        top      = top + ext_base + rec_len;
                        if (top >= IMAGE_BYTES)
                            bad_line = 1'b1;
                        else if (rec_type == TYPE_DATA) begin
                            if (total + rec_len > TOTAL_MAX)
                                total = TOTAL_MAX;
                            else
                                total = total + rec_len;
                        end
                    end
                    else if (b < 4 + rec_len) begin
                        if (rec_type == TYPE_DATA) begin
                            r.kind         = KIND_DATA;
                            r.byte_address = ADDR_W'(rec_off + ext_base + (b - 4));
                            r.byte_value   = bval[7:0];
                            r.line_status  = ST_DATA;
                            r.total_bytes  = total[TOTAL_W-1:0];
                            due_results.push_back(r);
                        end
                        else
                            base_acc = {base_acc[7:0], bval[7:0]};
                    end
                end
            end
        end
        if (pos < POS_MAX) pos++;
    endtask

    task automatic cmp_field(input string what, input logic [31:0] want,
                             input logic [31:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (due_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                     $time, m_tuser, m_tdata);
            return;
        end
        want = due_results.pop_front();
        cmp_field("kind", want.kind, m_tuser);
        cmp_field("byte_address", want.byte_address, m_tdata[16:0]);
        cmp_field("byte_value", want.byte_value, m_tdata[24:17]);
        cmp_field("line_status", want.line_status, m_tdata[27:25]);
        cmp_field("total_bytes", want.total_bytes, m_tdata[51:28]);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                parse_char(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                out_taken = 1'b1;
                check_result();
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: next request goes out at the falling edge after a gap
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        char_req_t req;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end
            else if (char_q.size() > 0) begin
                req = char_q.pop_front();
                s_tdata  <= req.ch;
                s_tvalid <= 1'b1;
                tx_wait  = req.gap;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stall after each result, long hold-off on demand
    always @(negedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (out_taken) begin
                rx_results++;
                if (rx_results % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------
    task automatic put_char(input logic [7:0] c);
        char_req_t req;
        req.ch  = c;
        req.gap = tx_calm ? 3'd0 : 3'($urandom_range(0, 6));
        char_q.push_back(req);
        gen_count++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return (($urandom_range(0, 1) != 0) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (digit_value(c) >= 0 || c == CHAR_LF || c == CHAR_CR)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_any();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_LF)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Data offset that keeps the record inside the image, now and then any offset
    function automatic int unsigned data_offset(input int unsigned len);
        int unsigned room;
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 16'hFFFF);
        room = IMAGE_BYTES - 1 - gen_base - len;
        if (room > 16'hFFFF) room = 16'hFFFF;
        return $urandom_range(0, room);
    endfunction

    // One record line. cut >= 0 stops after that many digits, bad_at >= 0 puts a
    // non-hex character at that digit, tail adds junk after the checksum.
    task automatic send_record(input int unsigned len, input int unsigned off,
                               input logic [7:0] typ, input logic [15:0] payload,
                               input bit good_sum, input int cut, input int bad_at,
                               input int tail);
        logic [7:0] bytes[$];
        logic [7:0] sum;
        logic [3:0] nib;
        int         i;
        int         k;
        bytes = {};
        bytes.push_back(len[7:0]);
        bytes.push_back(off[15:8]);
        bytes.push_back(off[7:0]);
        bytes.push_back(typ);
        for (i = 0; i < len; i++) begin
            if (typ != TYPE_DATA && len == 2)
                bytes.push_back((i == 0) ? payload[15:8] : payload[7:0]);
            else
                bytes.push_back(8'($urandom_range(0, 255)));
        end
        sum = 8'h00;
        for (i = 0; i < bytes.size(); i++) sum = sum + bytes[i];
        sum = ~sum + 8'd1;
        if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
        bytes.push_back(sum);

        put_char(CHAR_COLON);
        for (k = 0; k < 2 * bytes.size(); k++) begin
            if (cut >= 0 && k >= cut) break;
            nib = k[0] ? bytes[k / 2][3:0] : bytes[k / 2][7:4];
            put_char((k == bad_at) ? pick_non_hex() : hex_char(nib));
        end
        if (cut < 0)
            for (i = 0; i < tail; i++) put_char(pick_any());
        if ($urandom_range(0, 3) == 0) put_char(CHAR_CR);
        put_char(CHAR_LF);

        // follow the base the parser will take on
        if ((typ == TYPE_EXT_SEG || typ == TYPE_EXT_LIN) && len == 2 && good_sum &&
            cut < 0 && bad_at < 0 && off + gen_base + len < IMAGE_BYTES)
            gen_base = (typ == TYPE_EXT_SEG) ? {payload, 4'd0} : {payload, 16'd0};
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++) put_char(pick_any());
        put_char(CHAR_LF);
    endtask

    // Sender pause: everything taken and every result back
    task automatic drain();
        while (char_q.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        int          tail;
        int          i;
        logic [7:0]  typ;

        new_line();
        ext_base = 32'd0;
        eof_seen = 1'b0;
        total    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed records
        send_record(0, 0, TYPE_DATA, 0, 1, -1, -1, 0);             // empty data record
        send_record(255, 0, TYPE_DATA, 0, 1, -1, -1, 0);           // longest record
        send_record(4, 16'hFFFF, TYPE_DATA, 0, 1, -1, -1, 0);      // top offset
        send_record(1, 16'h0010, TYPE_DATA, 0, 0, -1, -1, 0);      // bad checksum, still counted
        send_record(2, 0, TYPE_EXT_LIN, 16'h0001, 1, -1, -1, 0);   // linear base 64K
        send_record(16, 16'hFFF0, TYPE_DATA, 0, 1, -1, -1, 0);     // ends right at image size
        send_record(15, 16'hFFF0, TYPE_DATA, 0, 1, -1, -1, 0);     // longest record the range check accepts
        send_record(2, 0, TYPE_EXT_SEG, 16'h1FFF, 1, -1, -1, 0);   // segment base near the top
        send_record(0, 16'h0020, TYPE_EOF, 0, 1, -1, -1, 0);       // end record out of range
        send_record(3, 0, TYPE_EXT_SEG, 0, 1, -1, -1, 0);          // base record, wrong length
        send_record(2, 0, TYPE_EXT_LIN, 0, 0, -1, -1, 0);          // base record, bad checksum
        send_record(2, 0, TYPE_EXT_LIN, 0, 1, -1, -1, 0);          // back to base zero
        send_record(4, 0, 8'h03, 0, 1, -1, -1, 0);                 // other record types
        send_record(0, 0, 8'h05, 0, 1, -1, -1, 0);
        send_record(1, 0, 8'hFF, 0, 1, -1, -1, 0);
        put_char(8'h58);                                           // missing colon
        send_noise(6);
        send_noise(0);                                             // empty line
        put_char(CHAR_CR);
        put_char(CHAR_LF);
        send_record(2, 16'h0200, TYPE_DATA, 0, 1, -1, 3, 0);       // non-hex in offset
        send_record(2, 16'h0210, TYPE_DATA, 0, 1, -1, 13, 0);      // non-hex in checksum
        send_record(4, 16'h0300, TYPE_DATA, 0, 1, 7, -1, 0);       // short line
        send_record(0, 0, TYPE_DATA, 0, 1, 0, -1, 0);              // colon alone
        send_record(0, 0, TYPE_EOF, 0, 1, 9, -1, 0);               // truncated end record
        send_record(3, 16'h0400, TYPE_DATA, 0, 1, -1, -1, 5);      // junk after checksum
        send_record(2, 16'h0500, TYPE_DATA, 0, 1, -1, -1, 1100);   // line past position limit
        send_record(2, 0, TYPE_EXT_SEG, 16'h0100, 1, -1, -1, 0);   // segment base 0x1000
        drain();

        // Receiver holds off while data keeps coming, so the input stalls
        rx_hold_left = HOLD_CYCLES;
        tx_calm      = 1'b1;
        for (i = 0; i < 12; i++)
            send_record(8, data_offset(8), TYPE_DATA, 0, 1, -1, -1, 0);
        tx_calm = 1'b0;

        // Random records, mostly well formed
        start = gen_count;
        while (gen_count - start < 1000) begin
            if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
            pick = $urandom_range(0, 99);
            tail = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
            if (pick < 55) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(0, 16);
                send_record(len, data_offset(len), TYPE_DATA, 0,
                            $urandom_range(0, 7) != 0, -1, -1, tail);
            end
            else if (pick < 63) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2;
                send_record(len, $urandom_range(0, 255), TYPE_EXT_SEG,
                            16'($urandom_range(0, 16'h1F00)),
                            $urandom_range(0, 7) != 0, -1, -1, tail);
            end
            else if (pick < 70) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2;
                send_record(len, $urandom_range(0, 255), TYPE_EXT_LIN,
                            16'($urandom_range(0, 1)),
                            $urandom_range(0, 7) != 0, -1, -1, tail);
            end
            else if (pick < 76) begin
                typ = 8'($urandom_range(3, 255));
                if (typ == TYPE_EXT_LIN) typ = 8'h03;
                send_record($urandom_range(0, 8), $urandom_range(0, 255), typ, 0,
                            $urandom_range(0, 1), -1, -1, tail);
            end
            else if (pick < 82) begin
                len = $urandom_range(0, 8);
                send_record(len, data_offset(len), TYPE_DATA, 0, 1,
                            $urandom_range(0, 9 + 2 * len), -1, 0);
            end
            else if (pick < 88) begin
                len = $urandom_range(0, 8);
                send_record(len, data_offset(len), TYPE_DATA, 0, 1, -1,
                            $urandom_range(0, 9 + 2 * len), tail);
            end
            else if (pick < 92)
                send_noise($urandom_range(0, 12));
            else if (pick < 96) begin
                // end records here are always cut short
                len = $urandom_range(0, 3);
                send_record(len, 0, TYPE_EOF, 0, 1, $urandom_range(0, 9 + 2 * len), -1, 0);
            end
            else begin
                len = $urandom_range(1, 8);
                send_record(len, data_offset(len), TYPE_DATA, 0, 1, -1, -1,
                            $urandom_range(1, 8));
            end
        end
        drain();

        // End record, then text that must produce nothing
        tx_calm = ($urandom_range(0, 1) != 0);
        send_record($urandom_range(0, 2), 0, TYPE_EOF, 16'($urandom_range(0, 16'hFFFF)),
                    $urandom_range(0, 1), -1, -1, 0);
        send_record(4, 16'h0040, TYPE_DATA, 0, 1, -1, -1, 0);
        send_noise(5);
        send_noise(0);
        drain();
        repeat (10) @(posedge clk);

        if (due_results.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d results expected, actual none", $time, due_results.size());
        end
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
